// ===== design/issgd_pkg.sv =====
// ----------------------------------------------------------------------------
// issgd_pkg: shared types and constants for the spin/stab gesture detector
// Holds widths, register indexes, controller states and command/status types.
// ----------------------------------------------------------------------------
package issgd_pkg;

  localparam int SampleBits = 16;
  localparam int CountBits  = 8;
  localparam int SqBits     = 2 * SampleBits + 2;  // sum of three squares
  localparam int RootBits   = SqBits / 2;
  localparam int CfgIdxBits = 3;
  localparam int CfgBits    = 16;

  localparam logic [CfgIdxBits-1:0] RegStabAccel  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegStabDur    = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegStabGyro   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegSpinStart  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegSpinStop   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegCircleTime = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegMinQuart   = 3'd6;

  typedef enum logic [2:0] {
    StIdle, StRootA, StRootG, StRootS, StUpdate, StOut
  } ctrl_state_e;

  typedef struct packed {
    logic capture;    // latch input beat
    logic root_start; // begin a square root
    logic [1:0] root_sel; // 0 accel, 1 gyro, 2 y-z gyro
    logic update;     // commit gesture state
  } ctrl_cmd_t;

  typedef struct packed {
    logic root_done;
    logic valid;      // captured data_valid
  } dp_status_t;

  localparam logic [1:0] SelAccel = 2'd0;
  localparam logic [1:0] SelGyro  = 2'd1;
  localparam logic [1:0] SelYz    = 2'd2;

endpackage

// ===== design/issgd_ctrl.sv =====
// ----------------------------------------------------------------------------
// issgd_ctrl: sequencer
// Steps one beat through three square roots (valid beats only), the state update and the output.
// ----------------------------------------------------------------------------
module issgd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  issgd_pkg::dp_status_t status_i,
  output issgd_pkg::ctrl_cmd_t  cmd_o
);
  import issgd_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StUpdate;
        end
      end
      StRootA: begin
        cmd_o.root_sel = SelAccel;
        if (status_i.root_done) begin
          cmd_o.root_start = 1'b1;
          cmd_o.root_sel = SelGyro;
          state_d = StRootG;
        end
      end
      StRootG: begin
        cmd_o.root_sel = SelGyro;
        if (status_i.root_done) begin
          cmd_o.root_start = 1'b1;
          cmd_o.root_sel = SelYz;
          state_d = StRootS;
        end
      end
      StRootS: begin
        cmd_o.root_sel = SelYz;
        if (status_i.root_done) begin
          cmd_o.update = 1'b1;
          state_d = StOut;
        end
      end
      StUpdate: begin
        // invalid samples skip the roots and commit swing state only
        if (status_i.valid) begin
          cmd_o.root_start = 1'b1;
          cmd_o.root_sel = SelAccel;
          state_d = StRootA;
        end else begin
          cmd_o.update = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

// ===== design/issgd_dp.sv =====
// ----------------------------------------------------------------------------
// issgd_dp: datapath
// Sums of squares, a shared bit-serial square root and the gesture state.
// ----------------------------------------------------------------------------
module issgd_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  issgd_pkg::ctrl_cmd_t                 cmd_i,
  output issgd_pkg::dp_status_t                status_o,
  input  logic                                 cfg_we_i,
  input  logic [issgd_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [issgd_pkg::CfgBits-1:0]        cfg_data_i,
  input  logic [31:0]                          time_ms_i,
  input  logic                                 data_valid_i,
  input  logic                                 swing_flag_i,
  input  logic                                 clash_flag_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] accel_x_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] accel_y_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] accel_z_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] gyro_x_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] gyro_y_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] gyro_z_i,
  output logic                                 swing_seen_o,
  output logic                                 clash_seen_o,
  output logic                                 no_data_o,
  output logic [1:0]                           spin_status_o,
  output logic                                 stab_seen_o
);
  import issgd_pkg::*;

  localparam int SB = SampleBits;
  localparam int AbsBits = SB;  // |x| fits in SB bits unsigned
  localparam int SqOne = 2 * SB;
  localparam logic [CountBits-1:0] CountMax = '1;
  localparam int StepBits = $clog2(RootBits + 1);

  // configuration
  logic [13:0] cfg_sacc_q;
  logic [15:0] cfg_sdur_q, cfg_ctime_q;
  logic [11:0] cfg_sgyro_q, cfg_sstart_q, cfg_sstop_q;
  logic [7:0]  cfg_mq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sacc_q <= 14'd2000; cfg_sdur_q <= 16'd3; cfg_sgyro_q <= 12'd360;
      cfg_sstart_q <= 12'd50; cfg_sstop_q <= 12'd50; cfg_ctime_q <= 16'd300;
      cfg_mq_q <= 8'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStabAccel:  cfg_sacc_q   <= cfg_data_i[13:0];
        RegStabDur:    cfg_sdur_q   <= cfg_data_i;
        RegStabGyro:   cfg_sgyro_q  <= cfg_data_i[11:0];
        RegSpinStart:  cfg_sstart_q <= cfg_data_i[11:0];
        RegSpinStop:   cfg_sstop_q  <= cfg_data_i[11:0];
        RegCircleTime: cfg_ctime_q  <= cfg_data_i;
        RegMinQuart:   cfg_mq_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // captured beat
  logic [31:0] t_q;
  logic valid_q, swf_q, clf_q;
  logic [AbsBits-1:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;

  function automatic logic [AbsBits-1:0] mag(input logic signed [SB-1:0] v);
    logic [SB-1:0] n;
    n = v[SB-1] ? (~v + 1'b1) : v;
    return n;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      t_q <= time_ms_i; valid_q <= data_valid_i;
      swf_q <= swing_flag_i; clf_q <= clash_flag_i;
      ax_q <= mag(accel_x_i); ay_q <= mag(accel_y_i); az_q <= mag(accel_z_i);
      gx_q <= mag(gyro_x_i); gy_q <= mag(gyro_y_i); gz_q <= mag(gyro_z_i);
    end
  end

  // square root: operand built one square a cycle would be tidier; the three
  // squares feed a shift-subtract root, one result bit a cycle
  logic [SqBits-1:0] rem_q, rad_q;
  logic [RootBits-1:0] root_q, root_a_q, root_g_q;
  logic [StepBits-1:0] step_q;
  logic busy_q;
  logic [1:0] sel_q;
  logic [SqOne-1:0] sq_p0, sq_p1, sq_p2;
  logic [SqBits-1:0] radicand;

  // one multiplier per axis, 16x16, before a register
  always_comb begin
    sq_p0 = '0; sq_p1 = '0; sq_p2 = '0;
    unique case (cmd_i.root_sel)
      SelAccel: begin sq_p0 = ax_q * ax_q; sq_p1 = ay_q * ay_q; sq_p2 = az_q * az_q; end
      SelGyro:  begin sq_p0 = gx_q * gx_q; sq_p1 = gy_q * gy_q; sq_p2 = gz_q * gz_q; end
      SelYz:    begin sq_p1 = gy_q * gy_q; sq_p2 = gz_q * gz_q; end
      default: ;
    endcase
    radicand = SqBits'(sq_p0) + SqBits'(sq_p1) + SqBits'(sq_p2);
  end

  logic [SqBits+1:0] trial;
  logic [SqBits-1:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[SqBits-3:0], rad_q[SqBits-1:SqBits-2]};
    trial = {2'b00, rem_sh} - {{(SqBits - RootBits){1'b0}}, root_q, 2'b01};
  end

  logic root_done;
  assign root_done = busy_q && (step_q == StepBits'(RootBits - 1)) ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; step_q <= '0;
    end else if (cmd_i.root_start) begin
      busy_q <= 1'b1; step_q <= '0;
    end else if (busy_q) begin
      if (root_done) busy_q <= 1'b0;
      step_q <= step_q + 1'b1;
    end
  end

  // the radicand is latched on root_start; each busy cycle after it yields
  // one root bit, RootBits bits in all
  logic [RootBits-1:0] root_next;
  always_comb begin
    root_next = trial[SqBits+1] ? {root_q[RootBits-2:0], 1'b0}
                                : {root_q[RootBits-2:0], 1'b1};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_start) begin
      rad_q <= radicand; rem_q <= '0; root_q <= '0; sel_q <= cmd_i.root_sel;
    end else if (busy_q) begin
      rad_q <= {rad_q[SqBits-3:0], 2'b00};
      rem_q <= trial[SqBits+1] ? rem_sh : trial[SqBits-1:0];
      root_q <= root_next;
    end
    // keep the finished root even when the next one starts on the same edge
    if (root_done) begin
      if (sel_q == SelAccel) root_a_q <= root_next;
      if (sel_q == SelGyro) root_g_q <= root_next;
    end
  end

  // root_done marks the last step; the final value is root_next
  assign status_o.root_done = root_done;
  assign status_o.valid = valid_q;

  // gesture state
  logic swing_q, spin_q, stab_q;
  logic [31:0] sw_t_q, sp_t_q, st_t_q;
  logic [CountBits-1:0] qc_q, cc_q;
  logic swing_seen_q, clash_seen_q, no_data_q, stab_seen_q;
  logic [1:0] spin_st_q;

  logic sw_n, sp_n, st_n, stab_rep;
  logic [31:0] sw_t_n, sp_t_n, st_t_n, tsw, tsp, dt;
  logic [CountBits-1:0] qc_n, cc_n;
  logic [1:0] spin_rep;
  logic signed [RootBits+1:0] acc_over, abs_over;
  logic [RootBits-1:0] s_root;
  logic [23:0] ct_mq;
  logic [33:0] q_lhs;
  logic [31+RootBits:0] tsw_s;
  logic [16+CountBits:0] circ_lim;
  logic [17:0] ct4;

  always_comb begin
    s_root = root_next;
    sw_n = swing_q; sw_t_n = sw_t_q;
    if (swf_q && !swing_q) begin sw_n = 1'b1; sw_t_n = t_q; end
    if (!swf_q) sw_n = 1'b0;
    sp_n = spin_q; sp_t_n = sp_t_q; st_n = stab_q; st_t_n = st_t_q;
    qc_n = qc_q; cc_n = cc_q; spin_rep = 2'd0; stab_rep = 1'b0;
    tsw = t_q - sw_t_n;
    tsp = t_q - sp_t_q;
    dt = t_q - st_t_q;
    acc_over = $signed({2'b00, root_a_q}) - (RootBits+2)'(1000);
    abs_over = acc_over[RootBits+1] ? -acc_over : acc_over;
    ct_mq = cfg_ctime_q * cfg_mq_q;
    q_lhs = {tsw, 2'b00};
    tsw_s = tsw * s_root;
    circ_lim = cfg_ctime_q * ({1'b0, cc_q} + 1'b1);
    ct4 = {cfg_ctime_q, 2'b00};
    if (valid_q) begin
      if (sw_n && (q_lhs > 34'(ct_mq) + 34'd360) && qc_n != CountMax)
        qc_n = qc_n + 1'b1;
      if (!spin_q && qc_n >= CountBits'(cfg_mq_q) && s_root > RootBits'(cfg_sstart_q)
          && tsw_s > (32+RootBits)'(cfg_ctime_q)) begin
        sp_n = 1'b1; sp_t_n = t_q;
      end else if (spin_q) begin
        if (s_root < RootBits'(cfg_sstop_q)) begin
          sp_n = 1'b0; qc_n = CountBits'(1); cc_n = '0;
        end else if (33'(tsp) > 33'(circ_lim)) begin
          if (cc_n != CountMax) cc_n = cc_n + 1'b1;
        end
      end
      if (!sw_n && !sp_n && tsw > 32'(ct4)) qc_n = '0;
      if (sp_n) spin_rep = (spin_q && cc_n > cc_q) ? 2'd2 : 2'd1;
      if (!stab_q && acc_over > $signed((RootBits+2)'(cfg_sacc_q))
          && $signed({2'b00, ax_q, 1'b0}) > abs_over) begin
        st_n = 1'b1; st_t_n = t_q;
      end else if (stab_q) begin
        if (root_g_q > RootBits'(cfg_sgyro_q)) st_n = 1'b0;
        else if (acc_over < $signed((RootBits+2)'(cfg_sacc_q)) || dt != 32'd0) begin
          st_n = 1'b0;
          stab_rep = dt > 32'(cfg_sdur_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swing_q <= 1'b0; spin_q <= 1'b0; stab_q <= 1'b0;
      sw_t_q <= '0; sp_t_q <= '0; st_t_q <= '0; qc_q <= '0; cc_q <= '0;
    end else if (cmd_i.update) begin
      swing_q <= sw_n; spin_q <= sp_n; stab_q <= st_n;
      sw_t_q <= sw_t_n; sp_t_q <= sp_t_n; st_t_q <= st_t_n;
      qc_q <= qc_n; cc_q <= cc_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      swing_seen_q <= swf_q; clash_seen_q <= clf_q;
      no_data_q <= !valid_q && !swf_q && !clf_q;
      spin_st_q <= spin_rep; stab_seen_q <= stab_rep;
    end
  end

  assign swing_seen_o = swing_seen_q;
  assign clash_seen_o = clash_seen_q;
  assign no_data_o = no_data_q;
  assign spin_status_o = spin_st_q;
  assign stab_seen_o = stab_seen_q;
endmodule

// ===== design/imu_spin_stab_gesture_detector.sv =====
// Sequence: each beat is captured, then (if data_valid) taken through three roots, then
// committed and offered. Throughput: one sample at a time; the shared
// bit-serial root runs three times per valid sample at one root bit a cycle.
// Reset: asynchronous, active low; clears gesture state, restores register
// defaults, and leaves the block ready for a beat.
// ----------------------------------------------------------------------------
// imu_spin_stab_gesture_detector: swing, clash, spin and stab detection
// Controller and datapath for one motion sample per result beat.
// ----------------------------------------------------------------------------
module imu_spin_stab_gesture_detector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [issgd_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [issgd_pkg::CfgBits-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [31:0]                          time_ms_i,
  input  logic                                 data_valid_i,
  input  logic                                 swing_flag_i,
  input  logic                                 clash_flag_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] accel_x_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] accel_y_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] accel_z_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] gyro_x_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] gyro_y_i,
  input  logic signed [issgd_pkg::SampleBits-1:0] gyro_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 swing_seen_o,
  output logic                                 clash_seen_o,
  output logic                                 no_data_o,
  output logic [1:0]                           spin_status_o,
  output logic                                 stab_seen_o
);
  import issgd_pkg::*;

  ctrl_cmd_t cmd;
  dp_status_t status;

  issgd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd)
  );

  issgd_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .time_ms_i, .data_valid_i, .swing_flag_i, .clash_flag_i,
    .accel_x_i, .accel_y_i, .accel_z_i, .gyro_x_i, .gyro_y_i, .gyro_z_i,
    .swing_seen_o, .clash_seen_o, .no_data_o, .spin_status_o, .stab_seen_o
  );

`ifndef ASSERT_OFF
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(spin_status_o))
    else $error("result dropped");
  a_spin_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> spin_status_o != 2'd3) else $error("bad spin code");
`endif
endmodule
